// ===== hw/rtl/lft_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LIN frame transmitter package
// Shared constants, the frame record passed between stages, and the
// protected identifier and length helpers.
// ----------------------------------------------------------------------------
package lft_pkg;

  localparam int MaxDataBytes = 8;
  localparam int InLenW       = 4;
  localparam int LenW         = $clog2(MaxDataBytes + 1);
  localparam int CntW         = $clog2(MaxDataBytes + 4);
  localparam int DataIdxW     = (MaxDataBytes > 1) ? $clog2(MaxDataBytes) : 1;
  localparam int HalfBytes    = (MaxDataBytes + 1) / 2;
  // Wide enough for the full sum of MaxDataBytes bytes.
  localparam int SumW         = 8 + $clog2(MaxDataBytes + 1);

  localparam logic [7:0] SyncByte  = 8'h55;
  localparam logic [7:0] BreakByte = 8'h00;

  // symbol_kind codes
  localparam logic KindBreak = 1'b0;
  localparam logic KindByte  = 1'b1;

  // Symbol positions within a frame
  localparam logic [CntW-1:0] SymBreak = CntW'(0);
  localparam logic [CntW-1:0] SymSync  = CntW'(1);
  localparam logic [CntW-1:0] SymPid   = CntW'(2);
  localparam logic [CntW-1:0] SymData0 = CntW'(3);

  typedef struct packed {
    logic [7:0]                    pid;
    logic [LenW-1:0]               len;
    logic [MaxDataBytes-1:0][7:0]  data;
  } frame_t;

  // Add the two LIN parity bits above the 6-bit identifier.
  function automatic logic [7:0] protect_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Clamp the requested length to the number of byte slots.
  function automatic logic [LenW-1:0] sat_len(input logic [InLenW-1:0] len);
    logic [LenW-1:0] res;
    if (int'(len) > MaxDataBytes) begin
      res = LenW'(MaxDataBytes);
    end else begin
      res = LenW'(len);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lin_frame_transmit_sequencer.sv =====
// An accepted request passes the prepare, sum, fold and serializer registers
//   before its break symbol is on the output. Throughput: one symbol per cycle
//   while out_ready_i is high; a frame of n data bytes is n + 4 symbols (at most 12) from the serializer.
// Requests enter back to back and wait in the three pipeline stages ahead of the serializer.
// Reset (rst_ni, asynchronous, active low) clears all valid bits and the
//   symbol counter; no frame is in flight afterward.
`default_nettype none
// ----------------------------------------------------------------------------
// LIN frame transmit sequencer
// Turns a frame request into break, sync, protected id, data bytes and the
// classic checksum, one symbol per output item.
// ----------------------------------------------------------------------------
module lin_frame_transmit_sequencer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // request channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [5:0] frame_id_i,
  input  wire logic [3:0] data_length_i,
  input  wire logic [7:0] data_byte_0_i,
  input  wire logic [7:0] data_byte_1_i,
  input  wire logic [7:0] data_byte_2_i,
  input  wire logic [7:0] data_byte_3_i,
  input  wire logic [7:0] data_byte_4_i,
  input  wire logic [7:0] data_byte_5_i,
  input  wire logic [7:0] data_byte_6_i,
  input  wire logic [7:0] data_byte_7_i,
  // symbol channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            symbol_kind_o,
  output logic [7:0]      byte_value_o,
  output logic            last_of_frame_o
);

  // Gather the byte ports into one array for the prepare stage.
  logic [7:0] in_bytes [8];
  assign in_bytes[0] = data_byte_0_i;
  assign in_bytes[1] = data_byte_1_i;
  assign in_bytes[2] = data_byte_2_i;
  assign in_bytes[3] = data_byte_3_i;
  assign in_bytes[4] = data_byte_4_i;
  assign in_bytes[5] = data_byte_5_i;
  assign in_bytes[6] = data_byte_6_i;
  assign in_bytes[7] = data_byte_7_i;

  logic            prep_valid, prep_ready;
  lft_pkg::frame_t prep_frame;
  logic            csum_valid, csum_ready;
  lft_pkg::frame_t csum_frame;
  logic [8:0]      csum_fold;

  // Stage 1: register request, clamp length, add parity to the id.
  lft_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .frame_id_i    (frame_id_i),
    .data_length_i (data_length_i),
    .data_i        (in_bytes),
    .valid_o       (prep_valid),
    .ready_i       (prep_ready),
    .frame_o       (prep_frame)
  );

  // Stages 2 and 3: half sums, then total with the first end-around fold.
  lft_csum u_csum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .frame_i (prep_frame),
    .valid_o (csum_valid),
    .ready_i (csum_ready),
    .frame_o (csum_frame),
    .fold_o  (csum_fold)
  );

  // Stage 4: hold one frame and step through its symbols. The next frame
  // loads in the same cycle its predecessor's checksum is taken.
  lft_serializer u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (csum_valid),
    .ready_o         (csum_ready),
    .frame_i         (csum_frame),
    .fold_i          (csum_fold),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .symbol_kind_o   (symbol_kind_o),
    .byte_value_o    (byte_value_o),
    .last_of_frame_o (last_of_frame_o)
  );

`ifndef NO_ASSERTIONS
  // The checksum that closes a frame is always a byte symbol.
  a_last_is_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_frame_o |-> symbol_kind_o == lft_pkg::KindByte)
    else $error("checksum symbol not marked as byte");

  // A break carries a zero byte and never ends a frame.
  a_break_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && symbol_kind_o == lft_pkg::KindBreak
      |-> byte_value_o == lft_pkg::BreakByte && !last_of_frame_o)
    else $error("break symbol with payload or end mark");

  // A frame, once started, runs to its checksum without gaps.
  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_frame_o |=> out_valid_o)
    else $error("frame interrupted before checksum");

  // Whatever follows a finished frame opens with a break.
  a_next_starts_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_of_frame_o
      |=> !out_valid_o || symbol_kind_o == lft_pkg::KindBreak)
    else $error("frame does not start with break");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/lft_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LIN frame prepare stage
// Registers the request, clamps the length and forms the protected id.
// ----------------------------------------------------------------------------
module lft_prep (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic [5:0]          frame_id_i,
  input  wire logic [lft_pkg::InLenW-1:0] data_length_i,
  input  wire logic [7:0]          data_i [8],
  output logic                     valid_o,
  input  wire logic                ready_i,
  output lft_pkg::frame_t          frame_o
);

  logic            valid_q;
  lft_pkg::frame_t frame_q, frame_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    frame_d.pid = lft_pkg::protect_id(frame_id_i);
    frame_d.len = lft_pkg::sat_len(data_length_i);
    for (int i = 0; i < lft_pkg::MaxDataBytes; i++) begin
      frame_d.data[i] = data_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      frame_q <= frame_d;
    end
  end

  assign valid_o = valid_q;
  assign frame_o = frame_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lft_csum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LIN classic checksum stages
// Two register stages: half sums of the used bytes, then total and first
// end-around fold.
// ----------------------------------------------------------------------------
module lft_csum (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire lft_pkg::frame_t frame_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output lft_pkg::frame_t      frame_o,
  output logic [8:0]           fold_o
);

  logic                       sum_valid_q;
  lft_pkg::frame_t            sum_frame_q;
  logic [lft_pkg::SumW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic                       sum_ready;

  logic                       fold_valid_q;
  lft_pkg::frame_t            fold_frame_q;
  logic [8:0]                 fold_q, fold_d;
  logic [lft_pkg::SumW-1:0]   total;

  // Drop bytes beyond the length, split the rest in two halves.
  always_comb begin
    logic [7:0] b;
    lo_d = '0;
    hi_d = '0;
    for (int i = 0; i < lft_pkg::MaxDataBytes; i++) begin
      b = (i < int'(frame_i.len)) ? frame_i.data[i] : 8'h00;
      if (i < lft_pkg::HalfBytes) begin
        lo_d = lo_d + lft_pkg::SumW'(b);
      end else begin
        hi_d = hi_d + lft_pkg::SumW'(b);
      end
    end
  end

  assign sum_ready = !fold_valid_q || ready_i;
  assign ready_o   = !sum_valid_q || sum_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (ready_o) begin
      sum_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sum_frame_q <= frame_i;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
    end
  end

  assign total  = lo_q + hi_q;
  assign fold_d = 9'(total[7:0]) + 9'(total[lft_pkg::SumW-1:8]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
    end else if (sum_ready) begin
      fold_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready && sum_valid_q) begin
      fold_frame_q <= sum_frame_q;
      fold_q       <= fold_d;
    end
  end

  assign valid_o = fold_valid_q;
  assign frame_o = fold_frame_q;
  assign fold_o  = fold_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lft_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// LIN frame serializer
// Holds one frame and steps through its symbols, one per accepted item.
// ----------------------------------------------------------------------------
module lft_serializer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire lft_pkg::frame_t frame_i,
  input  wire logic [8:0]      fold_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 symbol_kind_o,
  output logic [7:0]           byte_value_o,
  output logic                 last_of_frame_o
);

  logic                        valid_q;
  lft_pkg::frame_t             frame_q;
  logic [7:0]                  cks_q, cks_d;
  logic [lft_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [lft_pkg::CntW-1:0]    data_sel;
  logic [7:0]                  fold2;
  logic                        last;
  logic                        fire;

  // Second fold, then invert.
  assign fold2 = fold_i[7:0] + 8'(fold_i[8]);
  assign cks_d = ~fold2;

  assign last     = (cnt_q == lft_pkg::CntW'(frame_q.len) + lft_pkg::SymData0);
  assign fire     = valid_q && out_ready_i;
  assign ready_o  = !valid_q || (fire && last);
  assign data_sel = cnt_q - lft_pkg::SymData0;

  always_comb begin
    cnt_d = cnt_q;
    if (ready_o) begin
      cnt_d = lft_pkg::SymBreak;
    end else if (fire) begin
      cnt_d = cnt_q + lft_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= lft_pkg::SymBreak;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      frame_q <= frame_i;
      cks_q   <= cks_d;
    end
  end

  always_comb begin
    symbol_kind_o = lft_pkg::KindByte;
    byte_value_o  = lft_pkg::BreakByte;
    case (cnt_q)
      lft_pkg::SymBreak: begin
        symbol_kind_o = lft_pkg::KindBreak;
      end
      lft_pkg::SymSync: byte_value_o = lft_pkg::SyncByte;
      lft_pkg::SymPid:  byte_value_o = frame_q.pid;
      default: begin
        if (last) begin
          byte_value_o = cks_q;
        end else begin
          byte_value_o = frame_q.data[data_sel[lft_pkg::DataIdxW-1:0]];
        end
      end
    endcase
  end

  assign out_valid_o     = valid_q;
  assign last_of_frame_o = last;

endmodule
`default_nettype wire
